@@ src/yuvrgb_pkg.sv @@
// shared types, constants and helpers for the packed 4:2:2 to rgb converter
package yuvrgb_pkg;

	// byte order of the packed macropixel
	typedef enum logic [1:0] {
		ORDER_YUYV = 2'd0,
		ORDER_YVYU = 2'd1,
		ORDER_UYVY = 2'd2,
		ORDER_VYUY = 2'd3
	} input_order_t;

	// pixel packing on the output side
	typedef enum logic [1:0] {
		FMT_RGB565   = 2'd0,
		FMT_RGB888   = 2'd1,
		FMT_RGBA8888 = 2'd2
	} output_format_t;

	// register index, taken from the word address bit
	localparam logic REG_INPUT_ORDER   = 1'b0;
	localparam logic REG_OUTPUT_FORMAT = 1'b1;

	// conversion coefficients, all scaled by ten thousand
	localparam logic [13:0] K_R_CR = 14'd15938;
	localparam logic [21:0] OFS_R  = 22'd2221300;
	localparam logic [14:0] K_B_CB = 15'd20238;
	localparam logic [21:0] OFS_B  = 22'd2771300;
	localparam logic [13:0] K_Y    = 14'd11644;
	localparam logic [14:0] K_G_Y  = 15'd19837;
	localparam logic [18:0] OFS_G  = 19'd311710;
	localparam logic [12:0] K_G_R  = 13'd5094;
	localparam logic [10:0] K_G_B  = 11'd1942;
	localparam int          DIV_BASE = 10000;

	// floor(n / 10000) as (n * recip) >> 36, exact for n below 2^22
	localparam logic [22:0] DIV_RECIP = 23'd6871948;
	localparam int          DIV_SHIFT = 36;
	localparam logic signed [23:0] DIV_LIMIT = 24'(256 * DIV_BASE);

	// rgb565 field masks and the opaque alpha byte
	localparam logic [31:0] RGB565_R_MASK = 32'h0000F800;
	localparam logic [31:0] RGB565_G_MASK = 32'h000007E0;
	localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

	// one packed macropixel in stream order
	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic       last_pair;
	} yuv_word_t;

	// two packed output pixels
	typedef struct packed {
		logic [31:0] first_pixel;
		logic [31:0] second_pixel;
		logic        frame_end;
	} rgb_word_t;

	// divide by ten thousand, truncating toward zero, and clamp to 0..255
	function automatic logic [7:0] div_clamp(input logic signed [23:0] n);
		logic [44:0] prod;
		logic [7:0]  q;
		prod = {23'b0, n[21:0]} * {22'b0, DIV_RECIP};
		if (n[23]) begin
			q = 8'd0;
		end else if (n >= DIV_LIMIT) begin
			q = 8'd255;
		end else begin
			q = prod[DIV_SHIFT +: 8];
		end
		return q;
	endfunction

	// pack one pixel in the chosen format
	function automatic logic [31:0] pack_pixel(input output_format_t fmt,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [31:0] px;
		case (fmt)
			FMT_RGB565: begin
				px = (({24'b0, r} << 8) & RGB565_R_MASK)
					| (({24'b0, g} << 3) & RGB565_G_MASK)
					| {27'b0, b[7:3]};
			end
			FMT_RGB888: begin
				px = {8'b0, b, g, r};
			end
			default: begin
				px = {ALPHA_OPAQUE, b, g, r};
			end
		endcase
		return px;
	endfunction

endpackage

@@ src/yuv422_packed_to_rgb.sv @@
// packed 4:2:2 macropixel to two rgb pixels, five stage pipeline with apb registers

// Converts one packed 4:2:2 macropixel (four bytes, two lumas and a shared
// Cb/Cr pair) into two pixels packed as RGB565, RGB888 or RGBA8888. The
// block takes one word per clock while the output is not stalled, and returns
// one word per word taken. Each stage registers the word and holds one word; a
// stage only waits when the stage after it is full and stalled. The stages
// are: byte select and coefficient products, red/blue numerators and green
// base, red/blue divide and clamp, green numerator, green divide, clamp and
// packing. Registers sit on an APB port: input_order at 0x0, output_format at
// 0x4; change them only while the pipeline is empty.
module yuv422_packed_to_rgb (
	input  logic                   clk,
	input  logic                   arst_n,
	// pixel input
	input  logic                   yuv_valid,
	output logic                   yuv_ready,
	input  yuvrgb_pkg::yuv_word_t  yuv,
	// pixel output
	output logic                   rgb_valid,
	input  logic                   rgb_ready,
	output yuvrgb_pkg::rgb_word_t  rgb,
	// register port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import yuvrgb_pkg::*;

	// configuration registers
	input_order_t   order_q;
	output_format_t fmt_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic cap_s1, cap_s2, cap_s3, cap_s4, cap_s5;

	// stage one: coefficient products
	logic [21:0] pcr_s1;
	logic [22:0] pcb_s1;
	logic [21:0] py_s1 [2];
	logic [22:0] pg_s1 [2];
	logic        last_s1;

	// stage two: numerators of red, blue and the green base
	logic signed [23:0] nr_s2 [2];
	logic signed [23:0] nb_s2 [2];
	logic signed [23:0] ng_s2 [2];
	logic               last_s2;

	// stage three: clamped red and blue
	logic [7:0]         r_s3  [2];
	logic [7:0]         b_s3  [2];
	logic signed [23:0] ng_s3 [2];
	logic               last_s3;

	// stage four: green numerator
	logic [7:0]         r_s4  [2];
	logic [7:0]         b_s4  [2];
	logic signed [23:0] gn_s4 [2];
	logic               last_s4;

	// stage five: packed output word
	rgb_word_t out_s5;

	// byte selection
	logic [7:0] y_d [2];
	logic [7:0] cb_d, cr_d;

	// apb access
	assign pready = 1'b1;

	always_comb begin
		if (paddr[2] == REG_OUTPUT_FORMAT) begin
			prdata = {30'b0, fmt_q};
		end else begin
			prdata = {30'b0, order_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_YUYV;
			fmt_q   <= FMT_RGB565;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_INPUT_ORDER:   order_q <= input_order_t'(pwdata[1:0]);
				REG_OUTPUT_FORMAT: fmt_q   <= output_format_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	assign cap_s5    = !v_s5 || rgb_ready;
	assign cap_s4    = !v_s4 || cap_s5;
	assign cap_s3    = !v_s3 || cap_s4;
	assign cap_s2    = !v_s2 || cap_s3;
	assign cap_s1    = !v_s1 || cap_s2;
	assign yuv_ready = cap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (cap_s1) v_s1 <= yuv_valid;
			if (cap_s2) v_s2 <= v_s1;
			if (cap_s3) v_s3 <= v_s2;
			if (cap_s4) v_s4 <= v_s3;
			if (cap_s5) v_s5 <= v_s4;
		end
	end

	// pick lumas and chroma out of the macropixel
	always_comb begin
		unique case (order_q)
			ORDER_YUYV: begin
				y_d[0] = yuv.byte_zero; y_d[1] = yuv.byte_two;
				cb_d   = yuv.byte_one;  cr_d   = yuv.byte_three;
			end
			ORDER_YVYU: begin
				y_d[0] = yuv.byte_zero; y_d[1] = yuv.byte_two;
				cr_d   = yuv.byte_one;  cb_d   = yuv.byte_three;
			end
			ORDER_UYVY: begin
				cb_d   = yuv.byte_zero; y_d[0] = yuv.byte_one;
				cr_d   = yuv.byte_two;  y_d[1] = yuv.byte_three;
			end
			default: begin
				cr_d   = yuv.byte_zero; y_d[0] = yuv.byte_one;
				cb_d   = yuv.byte_two;  y_d[1] = yuv.byte_three;
			end
		endcase
	end

	// stage one: constant products
	always_ff @(posedge clk) begin
		if (yuv_valid && cap_s1) begin
			pcr_s1  <= {14'b0, cr_d} * {8'b0, K_R_CR};
			pcb_s1  <= {15'b0, cb_d} * {8'b0, K_B_CB};
			last_s1 <= yuv.last_pair;
			for (int i = 0; i < 2; i++) begin
				py_s1[i] <= {14'b0, y_d[i]} * {8'b0, K_Y};
				pg_s1[i] <= {15'b0, y_d[i]} * {8'b0, K_G_Y};
			end
		end
	end

	// stage two: add luma terms and offsets
	always_ff @(posedge clk) begin
		if (v_s1 && cap_s2) begin
			last_s2 <= last_s1;
			for (int i = 0; i < 2; i++) begin
				nr_s2[i] <= $signed({2'b0, pcr_s1}) + $signed({2'b0, py_s1[i]})
					- $signed({2'b0, OFS_R});
				nb_s2[i] <= $signed({1'b0, pcb_s1}) + $signed({2'b0, py_s1[i]})
					- $signed({2'b0, OFS_B});
				ng_s2[i] <= $signed({1'b0, pg_s1[i]}) - $signed({5'b0, OFS_G});
			end
		end
	end

	// stage three: divide and clamp red and blue
	always_ff @(posedge clk) begin
		if (v_s2 && cap_s3) begin
			last_s3 <= last_s2;
			for (int i = 0; i < 2; i++) begin
				r_s3[i]  <= div_clamp(nr_s2[i]);
				b_s3[i]  <= div_clamp(nb_s2[i]);
				ng_s3[i] <= ng_s2[i];
			end
		end
	end

	// stage four: subtract the clamped red and blue terms from green
	always_ff @(posedge clk) begin
		if (v_s3 && cap_s4) begin
			last_s4 <= last_s3;
			for (int i = 0; i < 2; i++) begin
				r_s4[i]  <= r_s3[i];
				b_s4[i]  <= b_s3[i];
				gn_s4[i] <= ng_s3[i]
					- $signed({16'b0, r_s3[i]} * {11'b0, K_G_R})
					- $signed({16'b0, b_s3[i]} * {13'b0, K_G_B});
			end
		end
	end

	// stage five: clamp green and pack both pixels
	always_ff @(posedge clk) begin
		if (v_s4 && cap_s5) begin
			out_s5.first_pixel  <= pack_pixel(fmt_q, r_s4[0], div_clamp(gn_s4[0]), b_s4[0]);
			out_s5.second_pixel <= pack_pixel(fmt_q, r_s4[1], div_clamp(gn_s4[1]), b_s4[1]);
			out_s5.frame_end    <= last_s4;
		end
	end

	assign rgb_valid = v_s5;
	assign rgb       = out_s5;

	// a full stage four behind a stalled stage five keeps its word
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !cap_s5) |=> (v_s4 && $stable(gn_s4[0]) && $stable(gn_s4[1])))
		else $error("stage four word changed while stalled");

	// a negative red numerator of the first pixel clamps to zero
	a_red_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && cap_s3) |=> (!$past(nr_s2[0][23]) || r_s3[0] == 8'd0))
		else $error("negative red numerator not clamped to zero");

	// rgba output always carries an opaque alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb_valid && fmt_q == FMT_RGBA8888)
		|-> (rgb.first_pixel[31:24] == ALPHA_OPAQUE
			&& rgb.second_pixel[31:24] == ALPHA_OPAQUE))
		else $error("rgba pixel without opaque alpha");

endmodule

@@ bench/yuv422_packed_to_rgb_test.sv @@
// self-checking bench for the packed 4:2:2 to rgb converter: directed and random words
`timescale 1ns / 1ps

// expected pixel words, worked out from the register settings at input time
class rgb_scoreboard;
	// conversion coefficients scaled by ten thousand
	localparam int R_FROM_CR = 15938;
	localparam int R_OFFSET  = 2221300;
	localparam int B_FROM_CB = 20238;
	localparam int B_OFFSET  = 2771300;
	localparam int LUMA_GAIN = 11644;
	localparam int G_FROM_Y  = 19837;
	localparam int G_OFFSET  = 311710;
	localparam int G_FROM_R  = 5094;
	localparam int G_FROM_B  = 1942;
	localparam int SCALE     = 10000;
	localparam logic [31:0] MASK_565_R = 32'h0000F800;
	localparam logic [31:0] MASK_565_G = 32'h000007E0;
	localparam logic [31:0] ALPHA_BYTE = 32'hFF000000;

	yuvrgb_pkg::rgb_word_t   expected_q[$];
	yuvrgb_pkg::input_order_t order_reg;
	logic [1:0]              format_reg;
	int mismatches;
	int words_in;
	int words_out;
	int frame_ends;

	function new();
		order_reg  = yuvrgb_pkg::ORDER_YUYV;
		format_reg = 2'd0;
		mismatches = 0;
		words_in   = 0;
		words_out  = 0;
		frame_ends = 0;
	endfunction

	// limit to one byte
	function int clip_byte(int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	// one pixel from a luma and the shared chroma pair, packed per the format
	function logic [31:0] convert_pixel(int luma, int cb, int cr);
		int r;
		int g;
		int b;
		logic [31:0] px;
		r = clip_byte((R_FROM_CR * cr - R_OFFSET + LUMA_GAIN * luma) / SCALE);
		b = clip_byte((B_FROM_CB * cb - B_OFFSET + LUMA_GAIN * luma) / SCALE);
		// green uses the clamped red and blue
		g = clip_byte((G_FROM_Y * luma - G_OFFSET - G_FROM_R * r - G_FROM_B * b) / SCALE);
		if (format_reg == yuvrgb_pkg::FMT_RGB565)
			px = ((32'(r) << 8) & MASK_565_R) | ((32'(g) << 3) & MASK_565_G) | (32'(b) >> 3);
		else if (format_reg == yuvrgb_pkg::FMT_RGB888)
			px = 32'(r) | (32'(g) << 8) | (32'(b) << 16);
		else
			px = 32'(r) | (32'(g) << 8) | (32'(b) << 16) | ALPHA_BYTE;
		return px;
	endfunction

	// note an accepted macropixel and queue the word it must produce
	function void note_input(yuvrgb_pkg::yuv_word_t w);
		int luma_a;
		int luma_b;
		int cb;
		int cr;
		yuvrgb_pkg::rgb_word_t want;
		case (order_reg)
			yuvrgb_pkg::ORDER_YUYV: begin
				luma_a = w.byte_zero; cb = w.byte_one; luma_b = w.byte_two; cr = w.byte_three;
			end
			yuvrgb_pkg::ORDER_YVYU: begin
				luma_a = w.byte_zero; cr = w.byte_one; luma_b = w.byte_two; cb = w.byte_three;
			end
			yuvrgb_pkg::ORDER_UYVY: begin
				cb = w.byte_zero; luma_a = w.byte_one; cr = w.byte_two; luma_b = w.byte_three;
			end
			default: begin
				cr = w.byte_zero; luma_a = w.byte_one; cb = w.byte_two; luma_b = w.byte_three;
			end
		endcase
		want.first_pixel  = convert_pixel(luma_a, cb, cr);
		want.second_pixel = convert_pixel(luma_b, cb, cr);
		want.frame_end    = w.last_pair;
		expected_q.push_back(want);
		words_in++;
	endfunction

	// compare an output word with the oldest expected one
	function void check_result(yuvrgb_pkg::rgb_word_t got);
		yuvrgb_pkg::rgb_word_t want;
		if (expected_q.size() == 0) begin
			$error("unexpected word: first_pixel %h second_pixel %h frame_end %b",
				got.first_pixel, got.second_pixel, got.frame_end);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		words_out++;
		if (got.frame_end)
			frame_ends++;
		if (got.first_pixel !== want.first_pixel) begin
			$error("first_pixel: expected %h, got %h", want.first_pixel, got.first_pixel);
			mismatches++;
		end
		if (got.second_pixel !== want.second_pixel) begin
			$error("second_pixel: expected %h, got %h", want.second_pixel, got.second_pixel);
			mismatches++;
		end
		if (got.frame_end !== want.frame_end) begin
			$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
			mismatches++;
		end
	endfunction
endclass

module yuv422_packed_to_rgb_test;
	import yuvrgb_pkg::*;

	localparam logic [2:0] ORDER_ADDR  = {REG_INPUT_ORDER, 2'b00};
	localparam logic [2:0] FORMAT_ADDR = {REG_OUTPUT_FORMAT, 2'b00};
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_WORDS = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        yuv_valid;
	logic        yuv_ready;
	yuv_word_t   yuv;
	logic        rgb_valid;
	logic        rgb_ready;
	rgb_word_t   rgb;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rgb_scoreboard board;
	int send_pct;
	int stall_pct;
	int quiet_cycles;

	yuv422_packed_to_rgb DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.yuv_valid (yuv_valid),
		.yuv_ready (yuv_ready),
		.yuv       (yuv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always #10 clk = ~clk;

	// output side: check each accepted word, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && rgb_valid && rgb_ready)
			board.check_result(rgb);
		if (arst_n)
			rgb_ready <= ($urandom_range(99) >= stall_pct);
		else
			rgb_ready <= 1'b0;
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((yuv_valid && yuv_ready) || (rgb_valid && rgb_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// idle pattern per phase
	task automatic set_mode(input int mode);
		case (mode)
			0: begin send_pct = 0;  stall_pct = 0;  end
			1: begin send_pct = 74; stall_pct = 0;  end
			2: begin send_pct = 0;  stall_pct = 74; end
			default: begin send_pct = 13; stall_pct = 13; end
		endcase
	endtask

	// register read, value checked against what was last written
	task automatic read_reg(input logic [2:0] addr, input logic [1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {30'b0, val}) begin
			$error("prdata at %h: expected %h, got %h", addr, {30'b0, val}, prdata);
			board.mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write with junk in the upper bits, then read back
	task automatic write_reg(input logic [2:0] addr, input logic [1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= ($urandom() & ~32'h3) | {30'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (addr)
			ORDER_ADDR:  board.order_reg = input_order_t'(val);
			FORMAT_ADDR: board.format_reg = val;
			default: ;
		endcase
		read_reg(addr, val);
	endtask

	// send one word, idling first at random
	task automatic push_word(input yuv_word_t w);
		while ($urandom_range(99) < send_pct) begin
			yuv_valid <= 1'b0;
			yuv       <= {$urandom(), 1'($urandom())};
			@(posedge clk);
		end
		yuv       <= w;
		yuv_valid <= 1'b1;
		@(posedge clk);
		while (!yuv_ready)
			@(posedge clk);
		board.note_input(w);
	endtask

	// stop sending and wait for every expected word, then let the pipe settle
	task automatic drain();
		yuv_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.expected_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// extremes and nominal video levels
	function automatic yuv_word_t directed_word(input int n);
		yuv_word_t w;
		case (n)
			0: w = {8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
			1: w = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
			2: w = {8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0};
			3: w = {8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1};
			4: w = {8'd16, 8'd128, 8'd235, 8'd128, 1'b0};
			default: w = {8'h55, 8'hAA, 8'h5A, 8'hA5, 1'b1};
		endcase
		return w;
	endfunction

	// byte biased toward the range ends and video levels
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(19))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'd16;
			3: return 8'd235;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic yuv_word_t random_word();
		yuv_word_t w;
		w.byte_zero  = pick_byte();
		w.byte_one   = pick_byte();
		w.byte_two   = pick_byte();
		w.byte_three = pick_byte();
		w.last_pair  = ($urandom_range(7) == 0);
		return w;
	endfunction

	// main sequence
	initial begin
		int k;
		int n;
		board        = new();
		arst_n       = 1'b0;
		yuv_valid    = 1'b0;
		yuv          = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		send_pct     = 0;
		stall_pct    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers come out of reset at zero
		read_reg(ORDER_ADDR, 2'd0);
		read_reg(FORMAT_ADDR, 2'd0);

		// directed words under each byte order, one packing code each
		for (k = 0; k < 4; k++) begin
			set_mode(k);
			write_reg(ORDER_ADDR, 2'(k));
			write_reg(FORMAT_ADDR, 2'(k));
			for (n = 0; n < 6; n++)
				push_word(directed_word(n));
			drain();
		end

		// random words over every order and packing pair
		for (k = 0; k < 16; k++) begin
			set_mode((k + k / 4) % 4);
			write_reg(ORDER_ADDR, 2'(k / 4));
			write_reg(FORMAT_ADDR, 2'(k % 4));
			for (n = 0; n < RANDOM_WORDS; n++) begin
				// hold off mid phase until the pipe is empty
				if (k % 3 == 1 && n == RANDOM_WORDS / 2)
					drain();
				push_word(random_word());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d macropixels in, %0d pixel pairs out, %0d frame ends",
			board.words_in, board.words_out, board.frame_ends);
		$display("four byte orders, four packing codes, four idle patterns, %0d mismatches",
			board.mismatches);
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/yuvrgb_pkg.sv
src/yuv422_packed_to_rgb.sv
bench/yuv422_packed_to_rgb_test.sv
